// ----- rtl/core/led_pkg.sv -----
`timescale 1ns / 1ps

package led_pkg;

    // Default capacity of the reference store and of the query.
    localparam int MAX_LEN_DEF = 64;

    // Result field widths and the saturation point of the distance.
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = 127;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_END    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FETCH,
        ST_LOAD
    } t_state;

    // Requests from the sequencer to the reference store.
    typedef struct packed {
        logic append;
        logic clear;
    } t_ref_ctl;

    // Requests from the sequencer to the row engine.
    typedef struct packed {
        logic start;   // begin a row walk for one query byte
        logic first;   // the stored row still holds its restart values
        logic fetch;   // read the last row entry for a result
    } t_walk_ctl;

endpackage

// ----- rtl/core/led_ref_store.sv -----
`timescale 1ns / 1ps

module led_ref_store #(
    parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  led_pkg::t_ref_ctl              i_ctl,
    input  logic [7:0]                     i_wr_byte,
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_LEN)-1:0]     i_rd_addr,
    output logic [7:0]                     o_rd_data,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_length,
    output logic                           o_full
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    logic [7:0]       mem [MAX_LEN];
    logic [LEN_W-1:0] r_length;
    logic [LEN_W-1:0] n_length;
    logic [7:0]       r_rd_data;
    logic             w_full;
    logic             w_wr_en;

    assign w_full  = (r_length == LEN_W'(MAX_LEN));
    assign w_wr_en = i_ctl.append && !w_full;

    always_comb begin
        n_length = r_length;
        if (i_ctl.clear) begin
            n_length = '0;
        end else if (w_wr_en) begin
            n_length = r_length + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else begin
            r_length <= n_length;
        end
    end

    // Only entries below the length are ever read, so the array needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_length[ADDR_W-1:0]] <= i_wr_byte;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_length  = r_length;
    assign o_full    = w_full;

endmodule

// ----- rtl/core/led_row_engine.sv -----
`timescale 1ns / 1ps

module led_row_engine #(
    parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  led_pkg::t_walk_ctl             i_ctl,
    input  logic [7:0]                     i_q,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_len,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_qc,
    output logic                           o_ref_rd_en,
    output logic [$clog2(MAX_LEN)-1:0]     o_ref_rd_addr,
    input  logic [7:0]                     i_ref_rd_data,
    output logic                           o_done,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_row_data
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int VAL_W  = $clog2(MAX_LEN + 1);

    // Row entry j (j >= 1) lives at address j-1; entry 0 always equals the
    // query count and is not stored.
    logic [VAL_W-1:0]  mem [MAX_LEN];
    logic [VAL_W-1:0]  r_rd_data;

    logic              r_issue;
    logic              r_stg;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_last;
    logic [ADDR_W-1:0] r_waddr;
    logic [VAL_W-1:0]  r_left;
    logic [VAL_W-1:0]  r_diag;
    logic [7:0]        r_q;
    logic              r_first;

    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_len_m1;
    logic [VAL_W-1:0]  w_above;
    logic [VAL_W:0]    w_up;
    logic [VAL_W:0]    w_lf;
    logic [VAL_W:0]    w_dg;
    logic [VAL_W:0]    w_m;
    logic [VAL_W-1:0]  w_new;
    logic [VAL_W-1:0]  w_len_dec;

    assign w_len_dec = i_len - VAL_W'(1);
    assign w_len_m1  = w_len_dec[ADDR_W-1:0];
    assign w_rd_en   = r_issue || i_ctl.fetch;
    assign w_rd_addr = i_ctl.fetch ? w_len_m1 : r_addr;

    // On the first query byte the row still holds j at entry j.
    assign w_above = r_first ? (VAL_W'(r_waddr) + VAL_W'(1)) : r_rd_data;
    assign w_up    = {1'b0, w_above} + (VAL_W + 1)'(1);
    assign w_lf    = {1'b0, r_left} + (VAL_W + 1)'(1);
    assign w_dg    = {1'b0, r_diag} + (VAL_W + 1)'(i_ref_rd_data != r_q);

    always_comb begin
        w_m = (w_up < w_lf) ? w_up : w_lf;
        if (w_dg < w_m) begin
            w_m = w_dg;
        end
        w_new = w_m[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_stg   <= 1'b0;
        end else begin
            r_stg <= r_issue;
            if (i_ctl.start) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_addr == r_last)) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_addr  <= '0;
            r_last  <= w_len_m1;
            r_left  <= i_qc + VAL_W'(1);
            r_diag  <= i_qc;
            r_q     <= i_q;
            r_first <= i_ctl.first;
        end else begin
            if (r_issue) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (r_stg) begin
                r_left <= w_new;
                r_diag <= w_above;
            end
        end
        if (r_issue) begin
            r_waddr <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_stg) begin
            mem[r_waddr] <= w_new;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    assign o_ref_rd_en   = r_issue;
    assign o_ref_rd_addr = r_addr;
    assign o_done        = r_stg && !r_issue;
    assign o_row_data    = r_rd_data;

endmodule

// ----- rtl/core/levenshtein_edit_distance_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)      tuser          Beat meaning
// s_axis    in   char_byte[7:0]          command[1:0]   one command
// m_axis    out  distance[6:0], 0 pad    overflow[0]    one distance result
//
// Append, clear and an ignored query byte complete when accepted. A query byte
// makes the row engine walk every entry of the stored reference, one row
// entry per cycle through its row memory, whose reads are registered. An end
// command fetches the result, then loads it once the result slot is free.
// Reset is synchronous and active low; no clearing pass is needed after reset.
// A result waits in the output register while the next beats are taken; a
// second end command stalls only until that result has been taken.

module levenshtein_edit_distance_unit #(
    parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0] i_s_axis_tuser,   // [1:0] command
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [6:0] distance, [7] zero
    output logic [0:0] o_m_axis_tuser    // [0] overflow
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int VAL_W  = $clog2(MAX_LEN + 1);
    localparam int SAT_W  = (VAL_W > led_pkg::DIST_W) ? VAL_W : led_pkg::DIST_W;

    led_pkg::t_state      r_state;
    led_pkg::t_state      n_state;
    led_pkg::t_cmd        w_cmd;
    led_pkg::t_ref_ctl    w_ref_ctl;
    led_pkg::t_walk_ctl   w_walk_ctl;

    logic                 w_accept;
    logic                 w_qfull;
    logic                 w_slot_free;
    logic                 w_load;

    logic [VAL_W-1:0]     r_qc;
    logic [VAL_W-1:0]     n_qc;
    logic                 r_ovf;
    logic                 n_ovf;
    logic [VAL_W-1:0]     r_res;
    logic                 r_use_mem;

    logic                       r_out_valid;
    logic [led_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_ovf;

    logic                 w_ref_rd_en;
    logic [ADDR_W-1:0]    w_ref_rd_addr;
    logic [7:0]           w_ref_rd_data;
    logic [VAL_W-1:0]     w_len;
    logic                 w_ref_full;
    logic                 w_done;
    logic [VAL_W-1:0]     w_row_data;
    logic [VAL_W-1:0]     w_dist_raw;
    logic [SAT_W-1:0]     w_dist_ext;

    assign w_cmd       = led_pkg::t_cmd'(i_s_axis_tuser);
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_qfull     = (r_qc == VAL_W'(MAX_LEN));
    assign w_slot_free = !r_out_valid || i_m_axis_tready;

    // Next-state logic of the command sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            led_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == led_pkg::CMD_QUERY && !w_qfull && w_len != '0) begin
                        n_state = led_pkg::ST_WALK;
                    end else if (w_cmd == led_pkg::CMD_END) begin
                        n_state = led_pkg::ST_FETCH;
                    end
                end
            end
            led_pkg::ST_WALK: begin
                if (w_done) begin
                    n_state = led_pkg::ST_IDLE;
                end
            end
            led_pkg::ST_FETCH: begin
                n_state = led_pkg::ST_LOAD;
            end
            led_pkg::ST_LOAD: begin
                if (w_slot_free) begin
                    n_state = led_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = led_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic of the command sequencer.
    always_comb begin
        o_s_axis_tready  = 1'b0;
        w_ref_ctl        = '0;
        w_walk_ctl       = '0;
        w_walk_ctl.first = (r_qc == '0);
        w_load           = 1'b0;
        case (r_state)
            led_pkg::ST_IDLE: begin
                o_s_axis_tready   = 1'b1;
                w_ref_ctl.append  = w_accept && (w_cmd == led_pkg::CMD_APPEND);
                w_ref_ctl.clear   = w_accept && (w_cmd == led_pkg::CMD_CLEAR);
                w_walk_ctl.start  = w_accept && (w_cmd == led_pkg::CMD_QUERY) &&
                                    !w_qfull && (w_len != '0);
            end
            led_pkg::ST_FETCH: begin
                w_walk_ctl.fetch = 1'b1;
            end
            led_pkg::ST_LOAD: begin
                w_load = w_slot_free;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // Query count and sticky overflow. Every command except a query byte
    // restarts the row.
    always_comb begin
        n_qc  = r_qc;
        n_ovf = r_ovf;
        if (w_accept) begin
            case (w_cmd)
                led_pkg::CMD_APPEND: begin
                    n_qc = '0;
                    if (w_ref_full) begin
                        n_ovf = 1'b1;
                    end
                end
                led_pkg::CMD_QUERY: begin
                    if (w_qfull) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_qc = r_qc + VAL_W'(1);
                    end
                end
                led_pkg::CMD_END: begin
                    n_qc = '0;
                end
                led_pkg::CMD_CLEAR: begin
                    n_qc  = '0;
                    n_ovf = 1'b0;
                end
                default: begin
                    n_qc = r_qc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= led_pkg::ST_IDLE;
            r_qc        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qc    <= n_qc;
            r_ovf   <= n_ovf;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // With an empty string on either side the distance is the other length,
    // so the row memory is consulted only when both are non-empty.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_cmd == led_pkg::CMD_END) begin
            r_res     <= (w_len == '0) ? r_qc : w_len;
            r_use_mem <= (w_len != '0) && (r_qc != '0);
        end
    end

    assign w_dist_raw = r_use_mem ? w_row_data : r_res;
    assign w_dist_ext = SAT_W'(w_dist_raw);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_dist <= (w_dist_ext > SAT_W'(led_pkg::DIST_MAX)) ?
                          led_pkg::DIST_W'(led_pkg::DIST_MAX) :
                          w_dist_ext[led_pkg::DIST_W-1:0];
            r_out_ovf  <= r_ovf;
        end
    end

    led_ref_store #(
        .MAX_LEN (MAX_LEN)
    ) u_ref_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ref_ctl),
        .i_wr_byte (i_s_axis_tdata),
        .i_rd_en   (w_ref_rd_en),
        .i_rd_addr (w_ref_rd_addr),
        .o_rd_data (w_ref_rd_data),
        .o_length  (w_len),
        .o_full    (w_ref_full)
    );

    led_row_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_row_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_walk_ctl),
        .i_q           (i_s_axis_tdata),
        .i_len         (w_len),
        .i_qc          (r_qc),
        .o_ref_rd_en   (w_ref_rd_en),
        .o_ref_rd_addr (w_ref_rd_addr),
        .i_ref_rd_data (w_ref_rd_data),
        .o_done        (w_done),
        .o_row_data    (w_row_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_dist};
    assign o_m_axis_tuser  = r_out_ovf;

endmodule

// ----- verif/levenshtein_edit_distance_unit_tb.sv -----
`timescale 1ns / 1ps

module levenshtein_edit_distance_unit_tb;

    localparam int MAX_LEN     = led_pkg::MAX_LEN_DEF;
    localparam int RAND_ITEMS  = 1000;
    localparam int HOLD_CYCLES = 600;
    localparam int DIR_ROWS    = 25;

    // One distance result as it leaves the block.
    typedef struct packed {
        logic [led_pkg::DIST_W-1:0] distance;
        logic                       overflow;
    } t_dist_result;

    // One row of the directed table. When has_fixed is set, the expected
    // result is typed in; otherwise the predictor supplies it.
    typedef struct packed {
        led_pkg::t_cmd cmd;
        logic [7:0]    chr;
        logic          has_fixed;
        t_dist_result  fixed_res;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] char_byte
    logic [1:0] i_s_axis_tuser;   // [1:0] command
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [6:0] distance, [7] zero
    logic [0:0] o_m_axis_tuser;   // [0] overflow

    levenshtein_edit_distance_unit #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Shadow copy of the block state, kept by the predictor.
    logic [7:0]        ref_bytes [MAX_LEN];
    logic [7:0]        ref_len;
    logic [7:0]        dp_row [MAX_LEN+1];
    logic [7:0]        qry_count;
    logic              ovf_seen;

    // Distances still owed by the block, oldest first.
    t_dist_result      dist_expect_q [$];

    int                err_cnt;
    int                items_taken;

    // Idle rates in percent, set by the stimulus process per phase.
    int                snd_idle_pct;
    int                rcv_idle_pct;

    // The long receiver hold-off is requested by the stimulus process and
    // counted out by the receiver process.
    bit                hold_go;
    bit                hold_done;

    // Directed table. It opens with an end command straight after reset,
    // runs empty-string cases, an exact match, an abandoned query, a clear,
    // and end and clear beats carrying a byte that must be ignored.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{led_pkg::CMD_END,    8'h00, 1'b1, '{7'd0, 1'b0}},   // empty vs empty after reset
        '{led_pkg::CMD_QUERY,  8'hFF, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_END,    8'h00, 1'b1, '{7'd1, 1'b0}},   // empty reference
        '{led_pkg::CMD_APPEND, 8'h00, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_APPEND, 8'hFF, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_APPEND, 8'h5A, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_END,    8'h00, 1'b1, '{7'd3, 1'b0}},   // empty query
        '{led_pkg::CMD_QUERY,  8'h00, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'h5A, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_END,    8'h00, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'h00, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'hFF, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'h5A, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_END,    8'hA5, 1'b1, '{7'd0, 1'b0}},   // exact match, byte ignored
        '{led_pkg::CMD_QUERY,  8'h77, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_APPEND, 8'h11, 1'b0, '{7'd0, 1'b0}},   // abandons the query
        '{led_pkg::CMD_END,    8'h00, 1'b1, '{7'd4, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'h11, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'h11, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_END,    8'h00, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_CLEAR,  8'hC3, 1'b0, '{7'd0, 1'b0}},   // byte ignored
        '{led_pkg::CMD_END,    8'hFF, 1'b1, '{7'd0, 1'b0}},
        '{led_pkg::CMD_APPEND, 8'h80, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_QUERY,  8'h01, 1'b0, '{7'd0, 1'b0}},
        '{led_pkg::CMD_END,    8'h00, 1'b0, '{7'd0, 1'b0}}
    };

    // A restart sets entry j of the row back to j and forgets the query.
    task automatic restart_dp_row();
        for (int j = 0; j <= MAX_LEN; j++) begin
            dp_row[j] = 8'(j);
        end
        qry_count = '0;
    endtask

    // Appends one expected result behind those already owed.
    task automatic queue_expected(input t_dist_result res);
        dist_expect_q = {dist_expect_q, res};
    endtask

    // Advances the shadow state by one accepted beat. An end command yields
    // a result, saturated to the widest distance the port can carry.
    task automatic edit_distance_step(input led_pkg::t_cmd cmd, input logic [7:0] chr,
                                      output bit emits, output t_dist_result res);
        logic [7:0] diag;
        logic [7:0] above;
        logic [7:0] cand;
        logic [7:0] cost;
        emits = 1'b0;
        res   = '0;
        case (cmd)
            led_pkg::CMD_APPEND: begin
                if (ref_len < MAX_LEN) begin
                    ref_bytes[ref_len] = chr;
                    ref_len = ref_len + 8'd1;
                end else begin
                    ovf_seen = 1'b1;
                end
                restart_dp_row();
            end
            led_pkg::CMD_QUERY: begin
                if (qry_count < MAX_LEN) begin
                    diag = dp_row[0];
                    qry_count = qry_count + 8'd1;
                    dp_row[0] = qry_count;
                    for (int j = 1; j <= ref_len; j++) begin
                        above = dp_row[j];
                        cost  = (ref_bytes[j-1] == chr) ? 8'd0 : 8'd1;
                        cand  = above + 8'd1;
                        if (dp_row[j-1] + 8'd1 < cand) begin
                            cand = dp_row[j-1] + 8'd1;
                        end
                        if (diag + cost < cand) begin
                            cand = diag + cost;
                        end
                        dp_row[j] = cand;
                        diag = above;
                    end
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            led_pkg::CMD_END: begin
                emits = 1'b1;
                res.distance = (dp_row[ref_len] > led_pkg::DIST_MAX) ?
                               led_pkg::DIST_W'(led_pkg::DIST_MAX) :
                               dp_row[ref_len][led_pkg::DIST_W-1:0];
                res.overflow = ovf_seen;
                restart_dp_row();
            end
            default: begin
                ref_len  = '0;
                ovf_seen = 1'b0;
                restart_dp_row();
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // Presents one beat at a falling edge after a random gap, then waits for
    // the rising edge where it is taken and updates the prediction there.
    task automatic send_beat(input led_pkg::t_cmd cmd, input logic [7:0] chr,
                             input logic has_fixed, input t_dist_result fixed_res);
        bit           emits;
        t_dist_result res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = chr;
        i_s_axis_tuser  = cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        edit_distance_step(cmd, chr, emits, res);
        items_taken++;
        if (emits) begin
            queue_expected(has_fixed ? fixed_res : res);
        end
    endtask

    task automatic send_cmd(input led_pkg::t_cmd cmd, input logic [7:0] chr);
        send_beat(cmd, chr, 1'b0, '0);
    endtask

    // Mostly draws from a four-letter alphabet so that matches are common,
    // otherwise from the whole byte range.
    function automatic logic [7:0] pick_char(input logic [7:0] base);
        if ($urandom_range(0, 99) < 70) begin
            return base + 8'($urandom_range(0, 3));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // A well-formed run: an optional clear, a reference, then one or more
    // queries against it, each closed by an end command.
    task automatic send_ref_query_burst(input int ref_n, input int q_n,
                                        input int rounds, input bit do_clear);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        if (do_clear) begin
            send_cmd(led_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < ref_n; i++) begin
            send_cmd(led_pkg::CMD_APPEND, pick_char(base));
        end
        for (int r = 0; r < rounds; r++) begin
            for (int i = 0; i < q_n; i++) begin
                send_cmd(led_pkg::CMD_QUERY, pick_char(base));
            end
            send_cmd(led_pkg::CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // Clock with a 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // Receiver side. Each falling edge decides whether the next rising edge
    // may take a result. Once requested, a long hold-off is counted out here
    // while the sender keeps offering beats, so the output register fills
    // and the block has to stall its input.
    initial begin
        int hold_cnt;
        hold_cnt        = 0;
        hold_done       = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                i_m_axis_tready = 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES) begin
                    hold_done = 1'b1;
                end
            end else begin
                i_m_axis_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Result checker. Every beat taken on the master side is compared,
    // field by field, with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_dist_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (dist_expect_q.size() == 0) begin
                report_mismatch("unexpected result, distance",
                                o_m_axis_tdata[led_pkg::DIST_W-1:0], -1);
            end else begin
                want = dist_expect_q.pop_front();
                if (o_m_axis_tdata[led_pkg::DIST_W-1:0] !== want.distance) begin
                    report_mismatch("distance", o_m_axis_tdata[led_pkg::DIST_W-1:0],
                                    want.distance);
                end
                if (o_m_axis_tuser[0] !== want.overflow) begin
                    report_mismatch("overflow", o_m_axis_tuser[0], want.overflow);
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // Main stimulus.
    initial begin
        int r;
        int rounds;
        int ref_n;
        int q_n;
        err_cnt         = 0;
        items_taken     = 0;
        hold_go         = 1'b0;
        snd_idle_pct    = 37;
        rcv_idle_pct    = 48;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = led_pkg::CMD_APPEND;
        for (int i = 0; i < MAX_LEN; i++) begin
            ref_bytes[i] = '0;
        end
        ref_len  = '0;
        ovf_seen = 1'b0;
        restart_dp_row();

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        for (int k = 0; k < DIR_ROWS; k++) begin
            send_beat(dir_tab[k].cmd, dir_tab[k].chr, dir_tab[k].has_fixed,
                      dir_tab[k].fixed_res);
        end

        // Random part in three phases: receiver-heavy idling, sender-heavy
        // idling, then none at all with the long receiver hold-off.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 37;
                    rcv_idle_pct = 48;
                    // Store full, with the flag staying set over two ends.
                    send_ref_query_burst(MAX_LEN + 2, 3, 2, 1'b1);
                    // Query too long against a short reference.
                    send_ref_query_burst(3, MAX_LEN + 2, 1, 1'b1);
                end
                1: begin
                    snd_idle_pct = 48;
                    rcv_idle_pct = 37;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    hold_go      = 1'b1;
                end
            endcase
            while (items_taken < DIR_ROWS + (ph + 1) * RAND_ITEMS / 3) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    // Fill the store to capacity or beyond; any overflow flag then
                    // persists until some later clear.
                    send_ref_query_burst(MAX_LEN + $urandom_range(0, 3),
                                         $urandom_range(0, 3), 1, 1'b1);
                end else if (r < 8) begin
                    send_ref_query_burst($urandom_range(0, 6),
                                         MAX_LEN + $urandom_range(0, 3), 1, 1'b1);
                end else if (r < 20) begin
                    // Noise: loose beats of any command, which also break
                    // queries in progress.
                    rounds = $urandom_range(1, 4);
                    for (int i = 0; i < rounds; i++) begin
                        send_cmd(led_pkg::t_cmd'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)));
                    end
                end else begin
                    ref_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN)
                                                         : $urandom_range(0, 8);
                    q_n    = $urandom_range(0, 10);
                    rounds = $urandom_range(1, 3);
                    send_ref_query_burst(ref_n, q_n, rounds, $urandom_range(0, 99) < 60);
                end
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        // Drain the outstanding results, then allow one full row walk more.
        while (dist_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (MAX_LEN + 8) @(posedge i_clk);

        if (dist_expect_q.size() != 0) begin
            report_mismatch("missing results, count", 0, dist_expect_q.size());
        end
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/led_pkg.sv
rtl/core/led_ref_store.sv
rtl/core/led_row_engine.sv
rtl/core/levenshtein_edit_distance_unit.sv
verif/levenshtein_edit_distance_unit_tb.sv
